@@ hdl/max_sum_k_disjoint_windows_top_defines.svh @@
// Assertion macros for the max-sum disjoint windows block.
// Each macro expects clk and rst in scope.
`ifndef MAX_SUM_K_DISJOINT_WINDOWS_TOP_DEFINES_SVH
`define MAX_SUM_K_DISJOINT_WINDOWS_TOP_DEFINES_SVH

// cond must hold at every edge out of reset
`define MSKW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define MSKW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define MSKW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mskw_pkg.sv @@
`default_nettype none

package mskw_pkg;

  // payload and register widths
  localparam int VALUE_W   = 32;
  localparam int SUM_W     = 48;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT  = 1'b1;

endpackage

`default_nettype wire

@@ hdl/max_sum_k_disjoint_windows_top.sv @@
// Best total of window_count disjoint runs of window_length consecutive values over a
// stream of unsigned items; the item marked last returns one result (best_sum, feasible)
// and starts a new sequence. Each item passes normalization (n ring-slot steps, zero
// unless window_length changed within a sequence, at most MAX_WINDOW_LEN/2), the window
// sum and a sweep over s, the number of window counts feasible at that item, one per
// cycle through the two read ports and the write port of the DP row memory, then a drain;
// the next item is accepted only once the previous one is done. An item marked last then
// waits for the output register; an item beyond MAX_ITEMS skips these steps and makes the
// answer infeasible. No clearing pass follows reset. window_length and window_count are
// saturated into 1..MAX_WINDOW_LEN and 1..MAX_WINDOWS.
`default_nettype none

`include "max_sum_k_disjoint_windows_top_defines.svh"

module max_sum_k_disjoint_windows_top #(
  parameter int MAX_ITEMS      = 4096,
  parameter int MAX_WINDOW_LEN = 64,
  parameter int MAX_WINDOWS    = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mskw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mskw_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mskw_pkg::VALUE_W-1:0]   value,
  input  wire logic                           last,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [mskw_pkg::SUM_W-1:0]     best_sum,
  output logic                                feasible
);
  import mskw_pkg::*;

  localparam int M_W    = $clog2(MAX_WINDOW_LEN + 1);
  localparam int K_W    = $clog2(MAX_WINDOWS + 1);
  localparam int S_W    = M_W;
  localparam int RING_W = $clog2(MAX_WINDOW_LEN + 3);
  localparam int D_W    = M_W + 1;
  localparam int RA_W   = (MAX_WINDOW_LEN > 1) ? $clog2(MAX_WINDOW_LEN) : 1;
  localparam int ROWS   = (MAX_WINDOW_LEN + 1) * MAX_WINDOWS;
  localparam int RW_A   = $clog2(ROWS);
  localparam int I_W    = $clog2(MAX_ITEMS + 1);
  localparam int P_W    = $clog2(MAX_WINDOWS * MAX_WINDOW_LEN + 1);
  localparam int CMP_W  = (P_W > I_W) ? P_W : I_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  // control state
  logic [2:0]         state;
  logic [CFG_W-1:0]   window_length;
  logic [CFG_W-1:0]   window_count;
  logic [I_W-1:0]     item_index;
  logic [SUM_W-1:0]   window_sum;
  logic [S_W-1:0]     row_pointer;
  logic               overflowed;
  logic [RA_W-1:0]    wptr;
  logic               p_valid;

  // per-item working registers
  logic [VALUE_W-1:0] v_r;
  logic               last_r;
  logic [M_W-1:0]     m_r;
  logic [K_W-1:0]     k_r;
  logic [RING_W-1:0]  ring_r;
  logic [S_W-1:0]     cur_prev;
  logic               old_ok;
  logic [K_W-1:0]     j;
  logic [P_W-1:0]     jm;
  logic [P_W-1:0]     km;
  logic [RW_A-1:0]    base_prev;
  logic [RW_A-1:0]    base_back;
  logic [RW_A-1:0]    base_new;
  logic               p_first;
  logic               p_keep;
  logic [RW_A-1:0]    p_waddr;

  // combinational helpers
  logic [M_W-1:0]     m_clamp;
  logic [K_W-1:0]     k_clamp;
  logic               accept;
  logic               skip;
  logic [D_W-1:0]     w_ext;
  logic [D_W-1:0]     m_ext;
  logic [D_W-1:0]     rd_diff;
  logic [RA_W-1:0]    recent_raddr;
  logic [VALUE_W-1:0] recent_rdata;
  logic               recent_we;
  logic [RING_W-1:0]  cp_ext;
  logic [RING_W-1:0]  plus1;
  logic [RING_W-1:0]  plus2;
  logic [S_W-1:0]     slot_new;
  logic [S_W-1:0]     slot_back;
  logic               issue;
  logic               keep_c;
  logic               row_re_a;
  logic [RW_A-1:0]    row_raddr_a;
  logic [RW_A-1:0]    row_raddr_b;
  logic [SUM_W-1:0]   row_rdata_a;
  logic [SUM_W-1:0]   row_rdata_b;
  logic               row_we;
  logic [SUM_W:0]     sum_a;
  logic [SUM_W:0]     cand;
  logic               res_load;
  logic               feas_c;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign skip      = overflowed || (item_index >= I_W'(MAX_ITEMS));

  // saturate the configuration registers
  always_comb begin
    if (window_length == '0) begin
      m_clamp = M_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW_LEN)) begin
      m_clamp = M_W'(MAX_WINDOW_LEN);
    end else begin
      m_clamp = M_W'(window_length);
    end
    if (window_count == '0) begin
      k_clamp = K_W'(1);
    end else if (32'(window_count) > 32'(MAX_WINDOWS)) begin
      k_clamp = K_W'(MAX_WINDOWS);
    end else begin
      k_clamp = K_W'(window_count);
    end
  end

  // slot of the value leaving the window: (index - m) mod ring depth
  assign w_ext        = D_W'(wptr);
  assign m_ext        = D_W'(m_clamp);
  assign rd_diff      = (w_ext >= m_ext) ? (w_ext - m_ext)
                                         : (w_ext + D_W'(MAX_WINDOW_LEN) - m_ext);
  assign recent_raddr = RA_W'(rd_diff);
  assign recent_we    = (state == S_SUM);

  // ring slots for this item
  assign cp_ext    = RING_W'(cur_prev);
  assign plus1     = cp_ext + RING_W'(1);
  assign plus2     = cp_ext + RING_W'(2);
  assign slot_new  = (plus1 == ring_r) ? '0 : S_W'(plus1);
  assign slot_back = (plus2 >= ring_r) ? S_W'(plus2 - ring_r) : S_W'(plus2);

  // sweep issue: count j is feasible when index >= j*m
  assign issue  = (state == S_SWEEP) && (CMP_W'(item_index) >= CMP_W'(jm));
  assign keep_c = CMP_W'(item_index) > CMP_W'(jm);

  // row memory addressing
  assign row_re_a    = (issue && (j != K_W'(1))) || (state == S_FIN);
  assign row_raddr_a = (state == S_FIN) ? (base_new + RW_A'(k_r - K_W'(1)))
                                        : (base_back + RW_A'(j - K_W'(2)));
  assign row_raddr_b = base_prev + RW_A'(j - K_W'(1));

  // update stage: take a run here or keep the previous best
  assign sum_a  = (p_first ? '0 : {1'b0, row_rdata_a}) + {1'b0, window_sum};
  assign cand   = (p_keep && ({1'b0, row_rdata_b} > sum_a)) ? {1'b0, row_rdata_b} : sum_a;
  assign row_we = p_valid;

  // result stage
  assign res_load = (state == S_RES) && (!out_valid || out_ready);
  assign feas_c   = !overflowed && (CMP_W'(item_index) >= CMP_W'(km));

  mskw_recent_mem #(
    .DEPTH (MAX_WINDOW_LEN),
    .AW    (RA_W)
  ) u_recent (
    .clk   (clk),
    .we    (recent_we),
    .waddr (wptr),
    .wdata (v_r),
    .re    (accept),
    .raddr (recent_raddr),
    .rdata (recent_rdata)
  );

  mskw_row_mem #(
    .DEPTH (ROWS),
    .AW    (RW_A)
  ) u_rows (
    .clk     (clk),
    .we      (row_we),
    .waddr   (p_waddr),
    .wdata   (cand[SUM_W-1:0]),
    .re_a    (row_re_a),
    .raddr_a (row_raddr_a),
    .rdata_a (row_rdata_a),
    .re_b    (issue),
    .raddr_b (row_raddr_b),
    .rdata_b (row_rdata_b)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(1);
      window_count  <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_WINDOW_COUNT:  window_count  <= cfg_data;
      endcase
    end
  end

  // sequencer and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      item_index  <= '0;
      window_sum  <= '0;
      row_pointer <= '0;
      overflowed  <= 1'b0;
      wptr        <= '0;
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      p_valid <= issue;
      if (p_valid && cand[SUM_W]) begin
        overflowed <= 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (skip) begin
              overflowed <= 1'b1;
              state      <= last ? S_FIN : S_IDLE;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (cp_ext < ring_r) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          window_sum  <= window_sum + SUM_W'(v_r)
                         - (old_ok ? SUM_W'(recent_rdata) : '0);
          wptr        <= (wptr == RA_W'(MAX_WINDOW_LEN - 1)) ? '0 : wptr + RA_W'(1);
          item_index  <= item_index + I_W'(1);
          row_pointer <= slot_new;
          state       <= S_SWEEP;
        end
        S_SWEEP: begin
          if (!issue || (j == K_W'(MAX_WINDOWS))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state <= S_RES;
        end
        S_RES: begin
          if (res_load) begin
            item_index  <= '0;
            window_sum  <= '0;
            row_pointer <= '0;
            overflowed  <= 1'b0;
            wptr        <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r      <= value;
      last_r   <= last;
      m_r      <= m_clamp;
      k_r      <= k_clamp;
      ring_r   <= RING_W'(m_clamp) + RING_W'(1);
      cur_prev <= row_pointer;
      old_ok   <= CMP_W'(item_index) >= CMP_W'(m_clamp);
    end
    // bring a stale slot back into the ring
    if ((state == S_NORM) && (cp_ext >= ring_r)) begin
      cur_prev <= S_W'(cp_ext - ring_r);
    end
    if (state == S_SUM) begin
      base_prev <= RW_A'(cur_prev) * RW_A'(MAX_WINDOWS);
      base_back <= RW_A'(slot_back) * RW_A'(MAX_WINDOWS);
      base_new  <= RW_A'(slot_new) * RW_A'(MAX_WINDOWS);
      j         <= K_W'(1);
      jm        <= P_W'(m_r);
    end
    if (issue) begin
      j       <= j + K_W'(1);
      jm      <= jm + P_W'(m_r);
      p_first <= (j == K_W'(1));
      p_keep  <= keep_c;
      p_waddr <= base_new + RW_A'(j - K_W'(1));
    end
    if (state == S_FIN) begin
      km <= P_W'(k_r) * P_W'(m_r);
    end
    if (res_load) begin
      best_sum <= feas_c ? row_rdata_a : '0;
      feasible <= feas_c;
    end
  end

  // checks
  `MSKW_ASSERT_IMPLY(a_infeasible_zero, out_valid && !feasible, best_sum == '0, "infeasible result with nonzero sum")
  `MSKW_ASSERT_IMPLY(a_no_row_collision, row_we && issue, (p_waddr != row_raddr_b) && (!row_re_a || (p_waddr != row_raddr_a)), "row write hits a row being read")
  `MSKW_ASSERT_IMPLY(a_slot_in_ring, state == S_SWEEP, cp_ext < ring_r, "ring slot out of range during sweep")
  `MSKW_ASSERT_NEXT(a_drain_empties, state == S_DRAIN, !row_we, "row write after drain")

endmodule

`default_nettype wire

@@ hdl/mskw_recent_mem.sv @@
`default_nettype none

// Ring of the most recent values, one write and one registered read port.
module mskw_recent_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [mskw_pkg::VALUE_W-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [mskw_pkg::VALUE_W-1:0] rdata
);
  import mskw_pkg::*;

  logic [VALUE_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/mskw_row_mem.sv @@
`default_nettype none

// DP row store: one write port, two registered read ports.
module mskw_row_mem #(
  parameter int DEPTH = 4160,
  parameter int AW    = 13
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [mskw_pkg::SUM_W-1:0] wdata,
  input  wire logic                       re_a,
  input  wire logic [AW-1:0]              raddr_a,
  output logic      [mskw_pkg::SUM_W-1:0] rdata_a,
  input  wire logic                       re_b,
  input  wire logic [AW-1:0]              raddr_b,
  output logic      [mskw_pkg::SUM_W-1:0] rdata_b
);
  import mskw_pkg::*;

  logic [SUM_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire
